// ===== design/stcl_pkg.sv =====
package stcl_pkg;

   localparam int COORD_W = 11;
   localparam int LOW_W   = 10;
   localparam int LEN_W   = 11;
   localparam int STAT_W  = 2;

   localparam logic REG_DOMAIN_LOW  = 1'b0;
   localparam logic REG_DOMAIN_HIGH = 1'b1;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] ST_SAT     = 2'd2;

   // walk phase of a tree node
   localparam logic [1:0] PH_ENTER = 2'd0;
   localparam logic [1:0] PH_LEFT  = 2'd1;
   localparam logic [1:0] PH_FINAL = 2'd2;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic step;
      logic rd_node;
      logic upd;
      logic fin;
      logic pop;
      logic rd_root;
      logic cap_root;
   } cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic       cfg_wr;
      logic       dom_ok;
      logic       seg_ok;
      logic       covered;
      logic [1:0] phase;
      logic       stack_empty;
   } sts_type;

endpackage

// ===== design/segment_tree_cover_length_core.sv =====
// Segment tree that tracks the union length of stored segments over the
// domain [domain_low, domain_high]. Each node keeps a cover count and its
// covered length in two single-port-write memories of 4*NUM_UNITS entries.
// One request is worked at a time: the update walk visits a partly covered
// node by entering it, stepping to its right child, reading it and writing
// it back, and a fully covered node by reading it and writing it back; it
// then reads the root length and presents the response. A request with a
// bad segment skips the walk and only reads the root, and one under a bad
// domain goes straight to the response. After reset and after every
// register write the memories are cleared one entry per cycle; while they
// are cleared no request is taken (register writes are still taken and restart the clear).
module segment_tree_cover_length_core #(
   parameter int NUM_UNITS  = 1024,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // seg_start[10:0], seg_end[21:11], zero fill
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // covered_length[10:0], zero fill
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);
   import stcl_pkg::*;

   cmd_type          cmd;
   sts_type          sts;
   logic             idle, busy_resp;
   logic             req_fire, rsp_fire, cfg_wr;
   logic [LEN_W-1:0] out_len;
   logic [STAT_W-1:0] out_status;

   assign csr_ready  = 1'b1;
   assign cfg_wr     = csr_valid && csr_ready;
   assign req_tready = idle;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = busy_resp;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {5'b0, out_len};
   assign rsp_tuser  = out_status;

   stcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .req_fire  (req_fire),
      .rsp_fire  (rsp_fire),
      .cmd       (cmd),
      .idle      (idle),
      .busy_resp (busy_resp)
   );

   stcl_dp #(
      .NUM_UNITS  (NUM_UNITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg_wr     (cfg_wr),
      .cfg_index  (csr_index),
      .cfg_data   (csr_data),
      .in_del     (req_tuser),
      .in_start   (req_tdata[10:0]),
      .in_end     (req_tdata[21:11]),
      .sts        (sts),
      .out_len    (out_len),
      .out_status (out_status)
   );

`ifndef SYNTHESIS
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("status code out of range");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:0] <= 11'd1024))
      else $error("covered length beyond domain");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !req_tready)
      else $error("request taken during clear");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("walk overlapped");
`endif

endmodule

// ===== design/stcl_ctrl.sv =====
module stcl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  stcl_pkg::sts_type sts,
   input  logic             req_fire,
   input  logic             rsp_fire,
   output stcl_pkg::cmd_type cmd,
   output logic             idle,
   output logic             busy_resp
);
   import stcl_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_VISIT, S_UPD, S_FIN, S_ROOT_RD, S_ROOT_WT, S_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               if (!sts.dom_ok) state_in = S_RESP;
               else if (!sts.seg_ok) state_in = S_ROOT_RD;
               else state_in = S_VISIT;
            end
         end
         S_VISIT: begin
            if (sts.phase == PH_FINAL) begin
               cmd.rd_node = 1'b1;
               state_in    = S_FIN;
            end else if (sts.phase == PH_ENTER && sts.covered) begin
               cmd.rd_node = 1'b1;
               state_in    = S_UPD;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_UPD, S_FIN: begin
            cmd.upd = (state_ff == S_UPD);
            cmd.fin = (state_ff == S_FIN);
            if (sts.stack_empty) begin
               state_in = S_ROOT_RD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_VISIT;
            end
         end
         S_ROOT_RD: begin
            cmd.rd_root = 1'b1;
            state_in    = S_ROOT_WT;
         end
         S_ROOT_WT: begin
            cmd.cap_root = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_fire) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
      // register write restarts the clearing pass
      if (sts.cfg_wr) state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle      = (state_ff == S_IDLE);
   assign busy_resp = (state_ff == S_RESP);

endmodule

// ===== design/stcl_dp.sv =====
module stcl_dp #(
   parameter int NUM_UNITS  = 1024,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  stcl_pkg::cmd_type                cmd,
   input  logic                            cfg_wr,
   input  logic                            cfg_index,
   input  logic [stcl_pkg::COORD_W-1:0]    cfg_data,
   input  logic                            in_del,
   input  logic [stcl_pkg::COORD_W-1:0]    in_start,
   input  logic [stcl_pkg::COORD_W-1:0]    in_end,
   output stcl_pkg::sts_type                sts,
   output logic [stcl_pkg::LEN_W-1:0]      out_len,
   output logic [stcl_pkg::STAT_W-1:0]     out_status
);
   import stcl_pkg::*;

   localparam int DEPTH    = 4 * NUM_UNITS;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int SI_W     = $clog2(ADDR_W);
   localparam int STK_DEPTH = 2 ** SI_W;
   localparam int SP_W     = SI_W + 1;

   typedef struct packed {
      logic [ADDR_W-1:0]  node;
      logic [COORD_W-1:0] lo;
      logic [COORD_W-1:0] hi;
      logic [1:0]         phase;
   } frame_type;

   logic [LOW_W-1:0]      dlow_ff;
   logic [COORD_W-1:0]    dhigh_ff;
   logic [COORD_W-1:0]    a_ff, b_ff;
   logic                  del_ff, sat_ff, bad_ff;
   frame_type             cur_ff;
   logic [SP_W-1:0]       sp_ff;
   frame_type             stack_ff [STK_DEPTH];
   logic [ADDR_W-1:0]     clr_cnt_ff;
   logic [LEN_W-1:0]      rsp_len_ff;
   logic [STAT_W-1:0]     rsp_st_ff;

   logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
   logic [LEN_W-1:0]      len_mem [DEPTH];
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [LEN_W-1:0]      lena_rd_ff, lenb_rd_ff;

   logic [COORD_W-1:0]    lo_ext, span, mid, dom_diff;
   logic [COORD_W:0]      mid_sum;
   logic                  leaf, need_left, need_right;
   logic [ADDR_W-1:0]     left_addr, right_addr, ra_a;
   logic [LEN_W:0]        child_sum;
   logic [LEN_W-1:0]      child_len;
   logic [COUNT_BITS-1:0] cnt_new;
   logic                  cnt_sat;
   logic                  wr_cnt, wr_len;
   logic [ADDR_W-1:0]     wa;
   logic [COUNT_BITS-1:0] wd_cnt;
   logic [LEN_W-1:0]      wd_len;
   logic [SI_W-1:0]       pop_idx;

   assign lo_ext     = {1'b0, dlow_ff};
   assign dom_diff   = dhigh_ff - lo_ext;
   assign span       = cur_ff.hi - cur_ff.lo;
   assign mid_sum    = {1'b0, cur_ff.lo} + {1'b0, cur_ff.hi};
   assign mid        = mid_sum[COORD_W:1];
   assign leaf       = (span <= COORD_W'(1));
   assign need_left  = (a_ff < mid);
   assign need_right = (b_ff > mid);
   assign left_addr  = {cur_ff.node[ADDR_W-2:0], 1'b0};
   assign right_addr = {cur_ff.node[ADDR_W-2:0], 1'b1};
   assign ra_a       = cmd.rd_root ? ADDR_W'(1) : left_addr;
   assign pop_idx    = SI_W'(sp_ff - SP_W'(1));

   assign sts.clr_last    = (clr_cnt_ff == ADDR_W'(DEPTH - 1));
   assign sts.cfg_wr      = cfg_wr;
   assign sts.dom_ok      = (dhigh_ff > lo_ext) && (32'(dom_diff) <= 32'(NUM_UNITS));
   assign sts.seg_ok      = (in_start < in_end) && (in_start >= lo_ext) && (in_end <= dhigh_ff);
   assign sts.covered     = (a_ff <= cur_ff.lo) && (cur_ff.hi <= b_ff);
   assign sts.phase       = cur_ff.phase;
   assign sts.stack_empty = (sp_ff == '0);

   assign child_sum = {1'b0, lena_rd_ff} + {1'b0, lenb_rd_ff};
   assign child_len = leaf ? '0 : child_sum[LEN_W-1:0];

   always_comb begin
      cnt_new = cnt_rd_ff;
      cnt_sat = 1'b0;
      if (del_ff == CMD_DELETE) begin
         if (cnt_rd_ff == '0) cnt_sat = 1'b1;
         else cnt_new = cnt_rd_ff - COUNT_BITS'(1);
      end else begin
         if (cnt_rd_ff == '1) cnt_sat = 1'b1;
         else cnt_new = cnt_rd_ff + COUNT_BITS'(1);
      end
   end

   always_comb begin
      wr_cnt = 1'b0;
      wr_len = 1'b0;
      wa     = cur_ff.node;
      wd_cnt = cnt_new;
      wd_len = '0;
      if (cmd.clr_step) begin
         wr_cnt = 1'b1;
         wr_len = 1'b1;
         wa     = clr_cnt_ff;
         wd_cnt = '0;
      end else if (cmd.upd) begin
         wr_cnt = 1'b1;
         wr_len = 1'b1;
         wd_len = (cnt_new != '0) ? LEN_W'(span) : child_len;
      end else if (cmd.fin) begin
         wr_len = 1'b1;
         wd_len = (cnt_rd_ff != '0) ? LEN_W'(span) : child_len;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cnt) cnt_mem[wa] <= wd_cnt;
      if (cmd.rd_node) cnt_rd_ff <= cnt_mem[cur_ff.node];
   end

   always_ff @(posedge clock) begin
      if (wr_len) len_mem[wa] <= wd_len;
      if (cmd.rd_node || cmd.rd_root) begin
         lena_rd_ff <= len_mem[ra_a];
         lenb_rd_ff <= len_mem[right_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dlow_ff    <= '0;
         dhigh_ff   <= COORD_W'(1024);
         clr_cnt_ff <= '0;
         sp_ff      <= '0;
      end else begin
         if (cfg_wr) begin
            if (cfg_index == REG_DOMAIN_LOW) dlow_ff <= cfg_data[LOW_W-1:0];
            else dhigh_ff <= cfg_data;
            clr_cnt_ff <= '0;
         end else if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (cmd.load) begin
            sp_ff <= '0;
         end else if (cmd.step) begin
            if ((cur_ff.phase == PH_ENTER && !leaf && need_left) ||
                (cur_ff.phase == PH_LEFT && need_right)) begin
               sp_ff <= sp_ff + SP_W'(1);
            end
         end else if (cmd.pop) begin
            sp_ff <= sp_ff - SP_W'(1);
         end
      end
   end

   // walk frame, stack and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff         <= in_start;
         b_ff         <= in_end;
         del_ff       <= in_del;
         sat_ff       <= 1'b0;
         bad_ff       <= !sts.seg_ok;
         cur_ff.node  <= ADDR_W'(1);
         cur_ff.lo    <= lo_ext;
         cur_ff.hi    <= dhigh_ff;
         cur_ff.phase <= PH_ENTER;
         if (!sts.dom_ok) begin
            rsp_len_ff <= '0;
            rsp_st_ff  <= ST_INVALID;
         end
      end else if (cmd.step) begin
         if (cur_ff.phase == PH_ENTER) begin
            if (leaf) begin
               cur_ff.phase <= PH_FINAL;
            end else if (need_left) begin
               stack_ff[sp_ff[SI_W-1:0]] <= '{node: cur_ff.node, lo: cur_ff.lo,
                                             hi: cur_ff.hi, phase: PH_LEFT};
               cur_ff <= '{node: left_addr, lo: cur_ff.lo, hi: mid, phase: PH_ENTER};
            end else begin
               cur_ff.phase <= PH_LEFT;
            end
         end else begin
            if (need_right) begin
               stack_ff[sp_ff[SI_W-1:0]] <= '{node: cur_ff.node, lo: cur_ff.lo,
                                             hi: cur_ff.hi, phase: PH_FINAL};
               cur_ff <= '{node: right_addr, lo: mid, hi: cur_ff.hi, phase: PH_ENTER};
            end else begin
               cur_ff.phase <= PH_FINAL;
            end
         end
      end else if (cmd.pop) begin
         cur_ff <= stack_ff[pop_idx];
      end
      if (cmd.upd && cnt_sat) sat_ff <= 1'b1;
      if (cmd.cap_root) begin
         rsp_len_ff <= lena_rd_ff;
         rsp_st_ff  <= bad_ff ? ST_INVALID : (sat_ff ? ST_SAT : ST_OK);
      end
   end

   assign out_len    = rsp_len_ff;
   assign out_status = rsp_st_ff;

endmodule
